FILE: rtl/ant_pkg.sv
// ant_pkg: shared types, codes and constants of the active note tracker.
// Used by ant_ctrl, ant_dp and active_note_tracker; depends on nothing else.

package ant_pkg;

    localparam int TRACKS_DEFAULT  = 4;
    localparam int NOTE_BITS       = 7;
    localparam int CHAN_BITS       = 4;
    localparam int TRACK_SPAN_BITS = NOTE_BITS + CHAN_BITS;

    // Command codes of an input item.
    localparam logic [1:0] CMD_NOTE_ON     = 2'd0;
    localparam logic [1:0] CMD_NOTE_OFF    = 2'd1;
    localparam logic [1:0] CMD_FLUSH_TRACK = 2'd2;
    localparam logic [1:0] CMD_FLUSH_ALL   = 2'd3;

    // Message kinds.
    localparam logic KIND_NOTE_ON  = 1'b0;
    localparam logic KIND_NOTE_OFF = 1'b1;

    // Result status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_RANGE     = 2'd1;
    localparam logic [1:0] STAT_SATURATED = 2'd2;
    localparam logic [1:0] STAT_NO_NOTE   = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [1:0]        track;
        logic [4:0]        channel;
        logic [3:0]        track_channel;
        logic [6:0]        note;
        logic signed [7:0] transpose;
        logic [6:0]        velocity;
    } in_item_t;

    typedef struct packed {
        logic       emit;
        logic       kind;
        logic [3:0] out_channel;
        logic [6:0] out_note;
        logic [6:0] out_velocity;
        logic [7:0] repeat_count;
        logic [1:0] status;
        logic       done_res;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic load;
        logic lookup;
        logic finish_item;
        logic scan_init;
        logic scan_step;
        logic scan_finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic is_flush;
        logic scan_hit;
        logic scan_empty;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/ant_ctrl.sv
// ant_ctrl: state machine that sequences the clearing pass, note lookups and flush scans.
// Depends on ant_pkg; drives the datapath ant_dp through command and status structs.

module ant_ctrl
    import ant_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t stat,
    output ctrl_cmd_t  cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DECODE = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (stat.is_flush) begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end else begin
                    cmd.lookup = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (stat.out_free) begin
                    cmd.finish_item = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // A found entry or an exhausted range waits for the result slot.
                if (stat.scan_hit || stat.scan_empty) begin
                    if (stat.out_free) begin
                        cmd.scan_finish = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/ant_dp.sv
// ant_dp: datapath with the note count memory, scan counters, item and result registers.
// Depends on ant_pkg; commanded by ant_ctrl.

module ant_dp
    import ant_pkg::*;
#(
    parameter int TRACKS = TRACKS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  ctrl_cmd_t  cmd,
    output dp_status_t stat,
    input  logic       cfg_valid,
    input  logic       cfg_data,
    input  in_item_t   s_item,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_item
);

    localparam int TW    = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int AW    = TW + TRACK_SPAN_BITS;
    localparam int DEPTH = TRACKS * (2 ** TRACK_SPAN_BITS);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    in_item_t  item_reg;
    out_item_t res_reg;
    out_item_t res_next;
    logic      m_valid_reg;
    logic      m_valid_next;
    logic      release_all_reg;

    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;
    logic [AW:0]   scan_addr_reg;
    logic [AW:0]   scan_addr_next;
    logic [AW:0]   scan_end_reg;
    logic [AW:0]   scan_end_next;
    logic [AW-1:0] rd_addr_reg;
    logic [AW-1:0] rd_addr_next;
    logic          rd_vld_reg;
    logic          rd_vld_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    logic                track_ok;
    logic [TW-1:0]       trk;
    logic [3:0]          ch;
    logic signed [8:0]   tn;
    logic                range_ok;
    logic [AW-1:0]       item_addr;
    logic [6:0]          tracks_lim;

    assign tracks_lim = 7'(TRACKS);
    assign track_ok   = ({5'b0, item_reg.track} < tracks_lim);
    assign trk        = TW'(item_reg.track);
    assign ch         = (item_reg.channel[4]) ? item_reg.track_channel
                                              : item_reg.channel[3:0];
    assign tn         = $signed({2'b00, item_reg.note})
                        + $signed({item_reg.transpose[7], item_reg.transpose});
    assign range_ok   = (tn[8:7] == 2'b00);
    assign item_addr  = {trk, ch, tn[6:0]};

    assign stat.clr_last   = (clr_addr_reg == AW'(DEPTH - 1));
    assign stat.is_flush   = (item_reg.cmd == CMD_FLUSH_TRACK)
                             || (item_reg.cmd == CMD_FLUSH_ALL);
    assign stat.scan_hit   = rd_vld_reg && (rdata_reg != 8'd0);
    assign stat.scan_empty = !rd_vld_reg && (scan_addr_reg >= scan_end_reg);
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_item  = res_reg;

    always_comb begin
        clr_addr_next  = clr_addr_reg;
        scan_addr_next = scan_addr_reg;
        scan_end_next  = scan_end_reg;
        rd_addr_next   = rd_addr_reg;
        rd_vld_next    = rd_vld_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        mem_we         = 1'b0;
        mem_waddr      = item_addr;
        mem_wdata      = 8'd0;
        mem_re         = 1'b0;
        mem_raddr      = item_addr;

        if (cmd.clr_step) begin
            mem_we        = 1'b1;
            mem_waddr     = clr_addr_reg;
            clr_addr_next = clr_addr_reg + AW'(1);
        end

        if (cmd.lookup) begin
            mem_re = track_ok && range_ok;
        end

        if (cmd.scan_init) begin
            rd_vld_next = 1'b0;
            if (item_reg.cmd == CMD_FLUSH_ALL) begin
                scan_addr_next = '0;
                scan_end_next  = (AW + 1)'(DEPTH);
            end else if (track_ok) begin
                scan_addr_next = {1'b0, trk, {TRACK_SPAN_BITS{1'b0}}};
                scan_end_next  = {(TW + 1)'(trk) + (TW + 1)'(1), {TRACK_SPAN_BITS{1'b0}}};
            end else begin
                scan_addr_next = '0;
                scan_end_next  = '0;
            end
        end

        if (cmd.scan_step) begin
            if (scan_addr_reg < scan_end_reg) begin
                mem_re         = 1'b1;
                mem_raddr      = scan_addr_reg[AW-1:0];
                rd_addr_next   = scan_addr_reg[AW-1:0];
                scan_addr_next = scan_addr_reg + (AW + 1)'(1);
                rd_vld_next    = 1'b1;
            end else begin
                rd_vld_next = 1'b0;
            end
        end

        if (cmd.scan_finish) begin
            m_valid_next = 1'b1;
            rd_vld_next  = 1'b0;
            res_next     = '0;
            if (rd_vld_reg) begin
                mem_we                = 1'b1;
                mem_waddr             = rd_addr_reg;
                mem_wdata             = rdata_reg - 8'd1;
                res_next.emit         = 1'b1;
                res_next.kind         = KIND_NOTE_OFF;
                res_next.out_channel  = rd_addr_reg[TRACK_SPAN_BITS-1:NOTE_BITS];
                res_next.out_note     = rd_addr_reg[NOTE_BITS-1:0];
                res_next.repeat_count = 8'd1;
                res_next.status       = STAT_OK;
            end else begin
                res_next.done_res = 1'b1;
            end
        end

        if (cmd.finish_item) begin
            m_valid_next = 1'b1;
            res_next     = '0;
            if (!track_ok) begin
                res_next.status = STAT_OK;
            end else if (!range_ok) begin
                res_next.status = STAT_RANGE;
            end else if (item_reg.cmd == CMD_NOTE_ON) begin
                res_next.emit         = 1'b1;
                res_next.kind         = KIND_NOTE_ON;
                res_next.out_channel  = ch;
                res_next.out_note     = tn[6:0];
                res_next.out_velocity = item_reg.velocity;
                res_next.repeat_count = 8'd1;
                if (rdata_reg == 8'hFF) begin
                    res_next.status = STAT_SATURATED;
                end else begin
                    res_next.status = STAT_OK;
                    mem_we          = 1'b1;
                    mem_wdata       = rdata_reg + 8'd1;
                end
            end else if (rdata_reg == 8'd0) begin
                res_next.status = STAT_NO_NOTE;
            end else begin
                mem_we                = 1'b1;
                mem_wdata             = release_all_reg ? 8'd0 : rdata_reg - 8'd1;
                res_next.emit         = 1'b1;
                res_next.kind         = KIND_NOTE_OFF;
                res_next.out_channel  = ch;
                res_next.out_note     = tn[6:0];
                res_next.out_velocity = item_reg.velocity;
                res_next.repeat_count = release_all_reg ? rdata_reg : 8'd1;
                res_next.status       = STAT_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_item;
        end
        res_reg       <= res_next;
        scan_addr_reg <= scan_addr_next;
        scan_end_reg  <= scan_end_next;
        rd_addr_reg   <= rd_addr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg    <= '0;
            rd_vld_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
            release_all_reg <= 1'b0;
        end else begin
            clr_addr_reg <= clr_addr_next;
            rd_vld_reg   <= rd_vld_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid) begin
                release_all_reg <= cfg_data;
            end
        end
    end

endmodule

FILE: rtl/active_note_tracker.sv
// active_note_tracker: a note-on or note-off item is registered, its count is read from the
// count memory and its result is registered; only then can the next item be taken.
// A flush scan reads the count memory one entry a cycle until it finds a nonzero entry or
// exhausts its range, which is 2048 entries for one track and TRACKS * 2048 for all tracks.
// A result that waits for m_ready holds the item and input. After reset a clearing pass zeroes
// the count memory before an item is taken; release_all resets to 0 and is always writable.

module active_note_tracker
    import ant_pkg::*;
#(
    parameter int TRACKS = TRACKS_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    assign cfg_ready = 1'b1;

    ant_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ant_dp #(
        .TRACKS (TRACKS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
